/* src/engine_command_sequencer_assert.svh */
// Assertion macros used by the checker of the engine command sequencer.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ENGINE_COMMAND_SEQUENCER_ASSERT_SVH
`define ENGINE_COMMAND_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ecs_pkg.sv */
// Package for the engine command sequencer: engine modes, command codes,
// valve and packet codes, register indexes and reset values. No dependencies.
package ecs_pkg;

  localparam int MODE_W = 3;
  localparam int CMD_W  = 4;
  localparam int PCT_W  = 7;
  localparam int CNT_W  = 9;

  // Engine modes.
  localparam logic [MODE_W-1:0] M_INIT     = 3'd0;
  localparam logic [MODE_W-1:0] M_SAFE     = 3'd1;
  localparam logic [MODE_W-1:0] M_UNSAFE   = 3'd2;
  localparam logic [MODE_W-1:0] M_IGNITION = 3'd3;
  localparam logic [MODE_W-1:0] M_LAUNCH   = 3'd4;
  localparam logic [MODE_W-1:0] M_ABORT    = 3'd5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ABORT  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ACK    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RESET  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SAFE   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_UNSAFE = 4'd4;
  localparam logic [CMD_W-1:0] CMD_IPA    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_NOS    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FIRE   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_OPEN   = 4'd8;

  // Item kinds.
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Valve actions.
  localparam logic [1:0] VA_NONE  = 2'd0;
  localparam logic [1:0] VA_CLOSE = 2'd1;
  localparam logic [1:0] VA_OPEN  = 2'd2;

  // Packet kinds.
  localparam logic [1:0] PKT_NONE   = 2'd0;
  localparam logic [1:0] PKT_TELEM  = 2'd1;
  localparam logic [1:0] PKT_STATUS = 2'd2;

  // Register indexes.
  localparam logic [2:0] CFG_LAUNCH_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_SILENCE_HALT   = 3'd1;
  localparam logic [2:0] CFG_LINK_RESTART   = 3'd2;
  localparam logic [2:0] CFG_PACKET_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_TELEM_PER_STAT = 3'd4;

  // Register reset values.
  localparam logic [31:0] RST_LAUNCH_TIMEOUT = 32'd1800000;
  localparam logic [31:0] RST_SILENCE_HALT   = 32'd30000;
  localparam logic [31:0] RST_LINK_RESTART   = 32'd3000;
  localparam logic [15:0] RST_PACKET_PERIOD  = 16'd100;
  localparam logic [7:0]  RST_TELEM_PER_STAT = 8'd10;

  // Highest heater duty accepted, in percent.
  localparam logic [15:0] DUTY_LIMIT = 16'd100;

  // One result item as held in the output register.
  typedef struct packed {
    logic [MODE_W-1:0] engine_state;
    logic [1:0]        valve_action;
    logic              ipa_heater_write;
    logic [PCT_W-1:0]  ipa_heater_pct;
    logic              nos_heater_write;
    logic [PCT_W-1:0]  nos_heater_pct;
    logic              fire_igniter;
    logic              send_ack;
    logic              storage_enable;
    logic [1:0]        packet_kind;
    logic              link_restart;
    logic              halted;
  } result_t;

endpackage

/* src/engine_command_sequencer.sv */
// Engine command sequencer top level: input register, mode and schedule logic,
// output register. Depends on ecs_pkg.
//
// Usage: each request on the in_ channel is either a time tick (in_action = 0)
// or a validated command (in_action = 1) with a millisecond timestamp. Every
// request yields exactly one result request on the out_ channel carrying the
// engine mode, valve and heater actions, igniter and ack pulses, the logging
// flag, the packet due and the link restart and halt flags.
// A request lands in the input register when it is accepted and passes through
// the update logic into the output register once that register is free.
// Throughput is one request per cycle while the receiver does not stall; the
// mode, silence and packet state update as each request moves on.
// The cfg_ port writes the five timing registers; write them only while no
// request is in flight.
// Reset (rst_n low, synchronous) empties both registers, puts the engine in
// init, clears all timers and flags and loads the register defaults.
// When the receiver stalls, the result holds in the output register, the next
// request waits in the input register, and only then is in_stall raised.
module engine_command_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [ecs_pkg::CMD_W-1:0]       in_command_code,
  input  logic [15:0]                     in_command_value,
  input  logic [31:0]                     in_time_ms,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ecs_pkg::MODE_W-1:0]      out_engine_state,
  output logic [1:0]                      out_valve_action,
  output logic                            out_ipa_heater_write,
  output logic [ecs_pkg::PCT_W-1:0]       out_ipa_heater_pct,
  output logic                            out_nos_heater_write,
  output logic [ecs_pkg::PCT_W-1:0]       out_nos_heater_pct,
  output logic                            out_fire_igniter,
  output logic                            out_send_ack,
  output logic                            out_storage_enable,
  output logic [1:0]                      out_packet_kind,
  output logic                            out_link_restart,
  output logic                            out_halted,
  // Configuration port
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import ecs_pkg::*;

  // Configuration registers.
  logic [31:0] launch_timeout_r;
  logic [31:0] silence_halt_r;
  logic [31:0] link_restart_r;
  logic [15:0] packet_period_r;
  logic [7:0]  telem_per_stat_r;

  // Input register.
  logic              in_vld_r;
  logic              in_action_r;
  logic [CMD_W-1:0]  in_code_r;
  logic [15:0]       in_value_r;
  logic [31:0]       in_time_r;

  // Engine state.
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [31:0]       last_cmd_r, last_cmd_nxt;
  logic [31:0]       restart_mark_r, restart_mark_nxt;
  logic [31:0]       launch_time_r, launch_time_nxt;
  logic [31:0]       next_pkt_r, next_pkt_nxt;
  logic [CNT_W-1:0]  pkt_cnt_r, pkt_cnt_nxt;
  logic              log_r, log_nxt;
  logic              halt_r, halt_nxt;

  // Output register.
  logic              out_vld_r;
  result_t           res_r, res_nxt;

  // Handshake control.
  logic out_free;
  logic fire;
  logic in_load;

  // Tick compares.
  logic [31:0] silence;
  logic [32:0] restart_sum;
  logic [32:0] launch_sum;
  logic        halt_hit;
  logic        restart_hit;
  logic        pkt_due;
  logic        status_due;
  logic        launch_expired;
  logic        duty_ok;
  logic [MODE_W-1:0] cmd_mode;

  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_load  = !in_vld_r || fire;
  assign in_stall = !in_load;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_timeout_r <= RST_LAUNCH_TIMEOUT;
      silence_halt_r   <= RST_SILENCE_HALT;
      link_restart_r   <= RST_LINK_RESTART;
      packet_period_r  <= RST_PACKET_PERIOD;
      telem_per_stat_r <= RST_TELEM_PER_STAT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LAUNCH_TIMEOUT: launch_timeout_r <= cfg_wdata;
        CFG_SILENCE_HALT:   silence_halt_r   <= cfg_wdata;
        CFG_LINK_RESTART:   link_restart_r   <= cfg_wdata;
        CFG_PACKET_PERIOD:  packet_period_r  <= cfg_wdata[15:0];
        CFG_TELEM_PER_STAT: telem_per_stat_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_action_r <= in_action;
      in_code_r   <= in_command_code;
      in_value_r  <= in_command_value;
      in_time_r   <= in_time_ms;
    end
  end

  // Compares used by ticks and commands, all in parallel.
  assign silence        = in_time_r - last_cmd_r;
  assign restart_sum    = {1'b0, restart_mark_r} + {1'b0, link_restart_r};
  assign launch_sum     = {1'b0, launch_time_r} + {1'b0, launch_timeout_r};
  assign halt_hit       = silence > silence_halt_r;
  assign restart_hit    = {1'b0, silence} > restart_sum;
  assign pkt_due        = next_pkt_r <= in_time_r;
  assign status_due     = pkt_cnt_r > {1'b0, telem_per_stat_r};
  assign launch_expired = {1'b0, in_time_r} > launch_sum;
  assign duty_ok        = in_value_r <= DUTY_LIMIT;
  // An abort command moves to abort before the per-mode rules run.
  assign cmd_mode       = (in_code_r == CMD_ABORT) ? M_ABORT : mode_r;

  // Next state and result for the item in the input register.
  always_comb begin
    mode_nxt         = mode_r;
    last_cmd_nxt     = last_cmd_r;
    restart_mark_nxt = restart_mark_r;
    launch_time_nxt  = launch_time_r;
    next_pkt_nxt     = next_pkt_r;
    pkt_cnt_nxt      = pkt_cnt_r;
    log_nxt          = log_r;
    halt_nxt         = halt_r;
    res_nxt          = '0;

    if (!halt_r) begin
      if (in_action_r == ACT_TICK) begin
        if (halt_hit) begin
          halt_nxt = 1'b1;
        end else begin
          // Link restart after each silence step.
          if (restart_hit) begin
            restart_mark_nxt     = silence;
            res_nxt.link_restart = 1'b1;
          end
          // Telemetry and status packet schedule.
          if (pkt_due) begin
            if (status_due) begin
              pkt_cnt_nxt         = '0;
              res_nxt.packet_kind = PKT_STATUS;
            end else begin
              pkt_cnt_nxt         = pkt_cnt_r + 1'b1;
              res_nxt.packet_kind = PKT_TELEM;
            end
            next_pkt_nxt = in_time_r + {16'd0, packet_period_r};
          end
          // Per-mode tick action.
          case (mode_r)
            M_INIT: begin
              res_nxt.valve_action = VA_CLOSE;
              mode_nxt             = M_SAFE;
            end
            M_UNSAFE, M_IGNITION: ;
            M_LAUNCH: begin
              if (launch_expired) begin
                mode_nxt             = M_ABORT;
                res_nxt.valve_action = VA_CLOSE;
                log_nxt              = 1'b0;
              end
            end
            default: log_nxt = 1'b0;
          endcase
        end
      end else begin
        last_cmd_nxt     = in_time_r;
        restart_mark_nxt = '0;
        mode_nxt         = cmd_mode;
        if (in_code_r == CMD_ABORT) begin
          res_nxt.valve_action = VA_CLOSE;
        end
        if (in_code_r == CMD_ACK) begin
          res_nxt.send_ack = 1'b1;
        end
        // Per-mode command rules.
        case (cmd_mode)
          M_SAFE, M_UNSAFE: begin
            if (in_code_r == CMD_UNSAFE && cmd_mode == M_SAFE) begin
              mode_nxt = M_UNSAFE;
              log_nxt  = 1'b1;
            end else if (in_code_r == CMD_SAFE && cmd_mode == M_UNSAFE) begin
              res_nxt.valve_action = VA_CLOSE;
              mode_nxt             = M_SAFE;
            end else if (in_code_r == CMD_IPA) begin
              res_nxt.ipa_heater_write = duty_ok;
              res_nxt.ipa_heater_pct   = duty_ok ? in_value_r[PCT_W-1:0] : '0;
            end else if (in_code_r == CMD_NOS) begin
              res_nxt.nos_heater_write = duty_ok;
              res_nxt.nos_heater_pct   = duty_ok ? in_value_r[PCT_W-1:0] : '0;
            end else if (in_code_r == CMD_FIRE && cmd_mode == M_UNSAFE) begin
              mode_nxt             = M_IGNITION;
              res_nxt.fire_igniter = 1'b1;
            end
          end
          M_IGNITION: begin
            if (in_code_r == CMD_SAFE) begin
              res_nxt.valve_action = VA_CLOSE;
              mode_nxt             = M_SAFE;
            end else if (in_code_r == CMD_OPEN) begin
              mode_nxt                 = M_LAUNCH;
              res_nxt.valve_action     = VA_OPEN;
              res_nxt.ipa_heater_write = 1'b1;
              res_nxt.nos_heater_write = 1'b1;
              launch_time_nxt          = in_time_r;
            end
          end
          M_LAUNCH: begin
            if (in_code_r == CMD_SAFE) begin
              res_nxt.valve_action = VA_CLOSE;
              mode_nxt             = M_SAFE;
            end
          end
          M_ABORT: begin
            if (in_code_r == CMD_RESET) begin
              mode_nxt = M_SAFE;
            end
          end
          default: ;
        endcase
      end
    end

    res_nxt.engine_state   = mode_nxt;
    res_nxt.storage_enable = log_nxt;
    res_nxt.halted         = halt_nxt;
  end

  // Engine state update, one item per cycle while the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= M_INIT;
      last_cmd_r     <= '0;
      restart_mark_r <= '0;
      launch_time_r  <= '0;
      next_pkt_r     <= '0;
      pkt_cnt_r      <= '0;
      log_r          <= 1'b0;
      halt_r         <= 1'b0;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      last_cmd_r     <= last_cmd_nxt;
      restart_mark_r <= restart_mark_nxt;
      launch_time_r  <= launch_time_nxt;
      next_pkt_r     <= next_pkt_nxt;
      pkt_cnt_r      <= pkt_cnt_nxt;
      log_r          <= log_nxt;
      halt_r         <= halt_nxt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_engine_state     = res_r.engine_state;
  assign out_valve_action     = res_r.valve_action;
  assign out_ipa_heater_write = res_r.ipa_heater_write;
  assign out_ipa_heater_pct   = res_r.ipa_heater_pct;
  assign out_nos_heater_write = res_r.nos_heater_write;
  assign out_nos_heater_pct   = res_r.nos_heater_pct;
  assign out_fire_igniter     = res_r.fire_igniter;
  assign out_send_ack         = res_r.send_ack;
  assign out_storage_enable   = res_r.storage_enable;
  assign out_packet_kind      = res_r.packet_kind;
  assign out_link_restart     = res_r.link_restart;
  assign out_halted           = res_r.halted;

endmodule

/* src/ecs_checker.sv */
// Port-level checker for the engine command sequencer, bound to the top level.
// Depends on ecs_pkg and engine_command_sequencer_assert.svh.
`include "engine_command_sequencer_assert.svh"

module ecs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ecs_pkg::MODE_W-1:0] out_engine_state,
  input logic [1:0]                 out_valve_action,
  input logic                       out_ipa_heater_write,
  input logic [ecs_pkg::PCT_W-1:0]  out_ipa_heater_pct,
  input logic                       out_fire_igniter,
  input logic                       out_send_ack,
  input logic [1:0]                 out_packet_kind,
  input logic                       out_link_restart,
  input logic                       out_halted
);
  import ecs_pkg::*;

  logic seen_halt_r;

  // Remember that a halted result has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && !out_stall && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  // Once halted, every later result reports halted.
  `ECS_ASSERT_NOW(a_halt_sticky, clk, rst_n, seen_halt_r && out_valid, out_halted,
                  "result lost the halted flag")

  // A halted result carries no actions or packets.
  `ECS_ASSERT_NOW(a_halt_quiet, clk, rst_n, out_valid && out_halted,
                  out_valve_action == VA_NONE && !out_fire_igniter && !out_send_ack &&
                  out_packet_kind == PKT_NONE && !out_link_restart,
                  "halted result carries an action")

  // The igniter fires only on entry to ignition.
  `ECS_ASSERT_NOW(a_fire_mode, clk, rst_n, out_valid && out_fire_igniter,
                  out_engine_state == M_IGNITION, "igniter pulse outside ignition")

  // The IPA heater percent only appears with a write, and never above the limit.
  `ECS_ASSERT_NOW(a_ipa_pct, clk, rst_n, out_valid,
                  (out_ipa_heater_write || out_ipa_heater_pct == '0) &&
                  out_ipa_heater_pct <= DUTY_LIMIT[PCT_W-1:0],
                  "bad first heater percent")

  // A stalled result stays offered.
  `ECS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
                   "stalled result withdrawn")

endmodule

bind engine_command_sequencer ecs_checker u_ecs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_engine_state     (out_engine_state),
  .out_valve_action     (out_valve_action),
  .out_ipa_heater_write (out_ipa_heater_write),
  .out_ipa_heater_pct   (out_ipa_heater_pct),
  .out_fire_igniter     (out_fire_igniter),
  .out_send_ack         (out_send_ack),
  .out_packet_kind      (out_packet_kind),
  .out_link_restart     (out_link_restart),
  .out_halted           (out_halted)
);
